@@ hw/rtl/lpfb_pkg.sv @@
// Shared types, constants and register indexes for the LED PWM flash/breath controller.
// Depends on nothing; every other file of the block refers to it by scoped names.
package lpfb_pkg;

    // Number of LEDs driven and the PWM scale
    localparam int NUM_LEDS = 2;
    localparam int LEVEL_W  = 5;
    localparam logic [LEVEL_W-1:0] MAX_LEVEL = 5'd19;

    // Mode field of the mode register, two bits per LED
    localparam int MODE_W       = 2;
    localparam int LED_MODES_W  = 4;
    localparam int MODED_LEDS   = LED_MODES_W / MODE_W;

    localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STEADY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLASH  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BREATH = 2'd3;

    // Field widths
    localparam int TIME_W    = 18;
    localparam int MS_W      = 16;
    localparam int COUNT_W   = 8;
    localparam int PERIOD_W  = 8;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_LED_MODES   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FLASH_LEVEL = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FLASH_COUNT = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ON_TIME     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_OFF_TIME    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_GAP_TIME    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_TASK_PERIOD = 3'd6;

    // Stream word widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_BITS    = 3 * NUM_LEDS;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Decoded settings seen by every LED unit
    typedef struct packed {
        logic [LED_MODES_W-1:0] led_modes;
        logic [LEVEL_W-1:0]     flash_lvl;    // already clamped to MAX_LEVEL
        logic [COUNT_W-1:0]     flash_count;
        logic [MS_W-1:0]        on_ms;
        logic [MS_W:0]          on_off_ms;    // on time plus off time
        logic [MS_W-1:0]        gap_ms;
        logic [PERIOD_W-1:0]    period_eff;   // task period, zero read as one
    } cfg_t;

    // Per-tick control from the top level to each LED unit
    typedef struct packed {
        logic clear;     // configuration written: drop all pattern state
        logic advance;   // a tick word accepted with the tick bit set
        logic step;      // this tick runs the pattern step
    } led_ctrl_t;

endpackage

@@ hw/rtl/led_pwm_flash_breath_controller.sv @@
// Top level of the LED PWM dimmer with steady, flash and breathing patterns.
// Depends on lpfb_pkg, lpfb_cfg_regs and lpfb_led_unit.
//
// Usage:
//   The input stream carries one word per millisecond; bit 0 of the word is
//   the tick bit. Each accepted word yields exactly one output word holding,
//   per LED, the PWM drive bit, a flash-cycle-done bit and a breath-done bit.
//   The drive bits reflect the levels held before that tick's pattern step.
//   The pattern step runs on the first tick after reset or a configuration
//   write, then once every task_period ticks (a period of zero counts as one).
//   A word whose tick bit is clear reports the drive bits and changes nothing.
//
//   The result word is valid in the cycle after its input word is taken.
//   Throughput: one word per cycle while the receiver keeps up. Each word is
//   handled by the per-LED update logic; the output register holds the result,
//   and input is still taken while it waits, provided the receiver takes the
//   held word in the same cycle. When the receiver stalls, hold the output
//   word and drop s_axis_tready until it is taken.
//
//   Configuration writes (cfg_we) take effect at once, are to be issued only
//   while no word is in flight, and clear all pattern and PWM state. Reset
//   loads the register defaults and clears all state; no clearing pass.
module led_pwm_flash_breath_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream; tdata: [0] tick, [7:1] zero
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [lpfb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Output stream; tdata: led_drive, flash_done, breath_done, then zero fill
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [lpfb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [lpfb_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [lpfb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int N = lpfb_pkg::NUM_LEDS;

    lpfb_pkg::cfg_t      cfg;
    lpfb_pkg::led_ctrl_t ctrl;
    logic                clear;
    logic                in_accept;
    logic                tick;

    logic [lpfb_pkg::PERIOD_W-1:0] step_divider_reg, step_divider_next;
    logic [lpfb_pkg::PERIOD_W:0]   step_divider_inc;

    logic [N-1:0] drive;
    logic [N-1:0] flash_done;
    logic [N-1:0] breath_done;

    logic         out_valid_reg, out_valid_next;
    logic [N-1:0] out_drive_reg;
    logic [N-1:0] out_fdone_reg;
    logic [N-1:0] out_bdone_reg;

    lpfb_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .clear     (clear)
    );

    // Take a new word whenever the output register is empty or being emptied
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign tick          = s_axis_tdata[0];

    assign ctrl.clear   = clear;
    assign ctrl.advance = in_accept && tick;
    assign ctrl.step    = (step_divider_reg == '0);

    // Step divider: count ticks, wrap at the effective period
    always_comb
    begin
        step_divider_inc  = {1'b0, step_divider_reg} + 9'd1;
        step_divider_next = step_divider_reg;
        if (ctrl.advance)
        begin
            step_divider_next = (step_divider_inc >= {1'b0, cfg.period_eff})
                                ? '0 : step_divider_inc[lpfb_pkg::PERIOD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_divider_reg <= '0;
        else if (clear)
            step_divider_reg <= '0;
        else
            step_divider_reg <= step_divider_next;
    end

    // One unit per LED; LEDs beyond the mode register stay off
    for (genvar i = 0; i < N; i++)
    begin : g_led
        logic [lpfb_pkg::MODE_W-1:0] mode;

        if (i < lpfb_pkg::MODED_LEDS)
        begin : g_mode
            assign mode = cfg.led_modes[lpfb_pkg::MODE_W*i +: lpfb_pkg::MODE_W];
        end
        else
        begin : g_off
            assign mode = lpfb_pkg::MODE_OFF;
        end

        lpfb_led_unit u_led (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .mode        (mode),
            .cfg         (cfg),
            .drive       (drive[i]),
            .flash_done  (flash_done[i]),
            .breath_done (breath_done[i])
        );
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_drive_reg <= drive;
            out_fdone_reg <= flash_done;
            out_bdone_reg <= breath_done;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(lpfb_pkg::OUT_TDATA_W - lpfb_pkg::OUT_BITS){1'b0}},
                            out_bdone_reg, out_fdone_reg, out_drive_reg};

`ifndef SYNTHESIS
    // A word with the tick bit clear never reports a completed pattern
    a_idle_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !tick) |=> (out_fdone_reg == '0 && out_bdone_reg == '0))
        else $error("done bit raised for a word without tick");

    // A LED cannot finish a flash and a breath cycle in the same tick
    a_done_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((out_fdone_reg & out_bdone_reg) == '0))
        else $error("flash and breath done on the same LED");

    // The divider always stays below the effective period
    a_divider_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_divider_reg < cfg.period_eff)
        else $error("step divider out of range");

    // A configuration write restarts the step schedule
    a_clear_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> (step_divider_reg == '0))
        else $error("step divider not cleared by configuration write");
`endif

endmodule

@@ hw/rtl/lpfb_cfg_regs.sv @@
// Configuration register file of the LED PWM flash/breath controller.
// Depends on lpfb_pkg; decodes the registers into lpfb_pkg::cfg_t and flags state clears.
module lpfb_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lpfb_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [lpfb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output lpfb_pkg::cfg_t                   cfg,
    output logic                             clear
);

    logic [lpfb_pkg::LED_MODES_W-1:0] led_modes_reg;
    logic [lpfb_pkg::COUNT_W-1:0]     flash_level_reg;
    logic [lpfb_pkg::COUNT_W-1:0]     flash_count_reg;
    logic [lpfb_pkg::MS_W-1:0]        on_time_reg;
    logic [lpfb_pkg::MS_W-1:0]        off_time_reg;
    logic [lpfb_pkg::MS_W-1:0]        gap_time_reg;
    logic [lpfb_pkg::PERIOD_W-1:0]    task_period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_modes_reg   <= 4'd9;
            flash_level_reg <= 8'd20;
            flash_count_reg <= 8'd1;
            on_time_reg     <= 16'd100;
            off_time_reg    <= 16'd100;
            gap_time_reg    <= 16'd2000;
            task_period_reg <= 8'd50;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                lpfb_pkg::REG_LED_MODES:
                    led_modes_reg <= cfg_wdata[lpfb_pkg::LED_MODES_W-1:0];
                lpfb_pkg::REG_FLASH_LEVEL:
                    flash_level_reg <= cfg_wdata[lpfb_pkg::COUNT_W-1:0];
                lpfb_pkg::REG_FLASH_COUNT:
                    flash_count_reg <= cfg_wdata[lpfb_pkg::COUNT_W-1:0];
                lpfb_pkg::REG_ON_TIME:     on_time_reg  <= cfg_wdata;
                lpfb_pkg::REG_OFF_TIME:    off_time_reg <= cfg_wdata;
                lpfb_pkg::REG_GAP_TIME:    gap_time_reg <= cfg_wdata;
                lpfb_pkg::REG_TASK_PERIOD:
                    task_period_reg <= cfg_wdata[lpfb_pkg::PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // Any write to a listed register wipes the pattern state
    always_comb
    begin
        case (cfg_addr)
            lpfb_pkg::REG_LED_MODES,
            lpfb_pkg::REG_FLASH_LEVEL,
            lpfb_pkg::REG_FLASH_COUNT,
            lpfb_pkg::REG_ON_TIME,
            lpfb_pkg::REG_OFF_TIME,
            lpfb_pkg::REG_GAP_TIME,
            lpfb_pkg::REG_TASK_PERIOD: clear = cfg_we;
            default:                   clear = 1'b0;
        endcase
    end

    always_comb
    begin
        cfg.led_modes   = led_modes_reg;
        cfg.flash_lvl   = (flash_level_reg > {3'd0, lpfb_pkg::MAX_LEVEL})
                          ? lpfb_pkg::MAX_LEVEL
                          : flash_level_reg[lpfb_pkg::LEVEL_W-1:0];
        cfg.flash_count = flash_count_reg;
        cfg.on_ms       = on_time_reg;
        cfg.on_off_ms   = {1'b0, on_time_reg} + {1'b0, off_time_reg};
        cfg.gap_ms      = gap_time_reg;
        cfg.period_eff  = (task_period_reg == '0) ? 8'd1 : task_period_reg;
    end

endmodule

@@ hw/rtl/lpfb_led_unit.sv @@
// One LED channel: PWM phase counter, level, flash and breath pattern state.
// Depends on lpfb_pkg for cfg_t, led_ctrl_t and the mode codes.
module lpfb_led_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lpfb_pkg::led_ctrl_t           ctrl,
    input  logic [lpfb_pkg::MODE_W-1:0]   mode,
    input  lpfb_pkg::cfg_t                cfg,
    output logic                          drive,
    output logic                          flash_done,
    output logic                          breath_done
);

    localparam logic [1:0] BR_UP   = 2'd0;
    localparam logic [1:0] BR_DOWN = 2'd1;
    localparam logic [1:0] BR_DARK = 2'd2;

    localparam logic [lpfb_pkg::TIME_W-1:0] TIME_MAX = '1;

    logic [lpfb_pkg::LEVEL_W-1:0] pwm_phase_reg,    pwm_phase_next;
    logic [lpfb_pkg::LEVEL_W-1:0] level_reg,        level_next;
    logic [1:0]                   breath_phase_reg, breath_phase_next;
    logic [lpfb_pkg::TIME_W-1:0]  pattern_time_reg, pattern_time_next;
    logic [lpfb_pkg::COUNT_W-1:0] pulses_done_reg,  pulses_done_next;

    // Flash step results
    logic [lpfb_pkg::LEVEL_W-1:0] f_level;
    logic [lpfb_pkg::TIME_W-1:0]  f_time_base;
    logic [lpfb_pkg::TIME_W:0]    f_time_sum;
    logic [lpfb_pkg::TIME_W-1:0]  f_time;
    logic [lpfb_pkg::COUNT_W-1:0] f_pulses;
    logic                         f_done;

    // Breath step results
    logic [lpfb_pkg::LEVEL_W-1:0] b_level;
    logic [1:0]                   b_phase;
    logic                         b_done;

    // Compare against the level held before this tick's step
    assign drive = (pwm_phase_reg < level_reg);

    always_comb
    begin
        f_level     = level_reg;
        f_time_base = pattern_time_reg;
        f_pulses    = pulses_done_reg;
        f_done      = 1'b0;
        if (pulses_done_reg < cfg.flash_count)
        begin
            if (pattern_time_reg < {2'd0, cfg.on_ms})
            begin
                f_level = cfg.flash_lvl;
            end
            else if (pattern_time_reg < {1'b0, cfg.on_off_ms})
            begin
                f_level = '0;
            end
            else
            begin
                f_time_base = '0;
                f_pulses    = pulses_done_reg + 8'd1;
            end
        end
        else if (pattern_time_reg < {2'd0, cfg.gap_ms})
        begin
            f_level = '0;
        end
        else
        begin
            f_time_base = '0;
            f_pulses    = '0;
            f_done      = 1'b1;
        end
        // Advance pattern time by one period, saturating
        f_time_sum = {1'b0, f_time_base} + {11'd0, cfg.period_eff};
        f_time     = f_time_sum[lpfb_pkg::TIME_W] ? TIME_MAX
                                                  : f_time_sum[lpfb_pkg::TIME_W-1:0];
    end

    always_comb
    begin
        b_level = level_reg;
        b_phase = breath_phase_reg;
        b_done  = 1'b0;
        case (breath_phase_reg)
            BR_UP:
            begin
                if (level_reg < lpfb_pkg::MAX_LEVEL)
                    b_level = level_reg + 5'd1;
                if (b_level >= lpfb_pkg::MAX_LEVEL)
                    b_phase = BR_DOWN;
            end
            BR_DOWN:
            begin
                if (level_reg != '0)
                    b_level = level_reg - 5'd1;
                if (b_level == '0)
                    b_phase = BR_DARK;
            end
            BR_DARK:
            begin
                b_level = '0;
                b_phase = BR_UP;
                b_done  = 1'b1;
            end
            default:
            begin
                b_phase = BR_UP;
            end
        endcase
    end

    always_comb
    begin
        pwm_phase_next    = pwm_phase_reg;
        level_next        = level_reg;
        breath_phase_next = breath_phase_reg;
        pattern_time_next = pattern_time_reg;
        pulses_done_next  = pulses_done_reg;
        flash_done        = 1'b0;
        breath_done       = 1'b0;
        if (ctrl.advance)
        begin
            pwm_phase_next = (pwm_phase_reg > lpfb_pkg::MAX_LEVEL)
                             ? '0 : pwm_phase_reg + 5'd1;
            if (ctrl.step)
            begin
                case (mode)
                    lpfb_pkg::MODE_OFF:    level_next = '0;
                    lpfb_pkg::MODE_STEADY: level_next = lpfb_pkg::MAX_LEVEL;
                    lpfb_pkg::MODE_FLASH:
                    begin
                        level_next        = f_level;
                        pattern_time_next = f_time;
                        pulses_done_next  = f_pulses;
                        flash_done        = f_done;
                    end
                    default:
                    begin
                        level_next        = b_level;
                        breath_phase_next = b_phase;
                        breath_done       = b_done;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_phase_reg    <= '0;
            level_reg        <= '0;
            breath_phase_reg <= BR_UP;
            pattern_time_reg <= '0;
            pulses_done_reg  <= '0;
        end
        else if (ctrl.clear)
        begin
            pwm_phase_reg    <= '0;
            level_reg        <= '0;
            breath_phase_reg <= BR_UP;
            pattern_time_reg <= '0;
            pulses_done_reg  <= '0;
        end
        else
        begin
            pwm_phase_reg    <= pwm_phase_next;
            level_reg        <= level_next;
            breath_phase_reg <= breath_phase_next;
            pattern_time_reg <= pattern_time_next;
            pulses_done_reg  <= pulses_done_next;
        end
    end

endmodule
